FILE: hdl/per_source_rate_limiter_unit_assert.svh
// Assertion macros for the rate limiter
`ifndef PER_SOURCE_RATE_LIMITER_UNIT_ASSERT_SVH
`define PER_SOURCE_RATE_LIMITER_UNIT_ASSERT_SVH

// same-cycle implication on clk, disabled during reset
`define PRL_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication on clk, disabled during reset
`define PRL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/prl_pkg.sv
package prl_pkg;

	localparam int TableEntries = 64;
	localparam int IdxW = $clog2(TableEntries);

	typedef struct packed {
		logic        valid;
		logic [31:0] addr;
		logic [31:0] count;
		logic [63:0] wstart;
		logic [31:0] drops;
	} entry_t;

	localparam int EntryW = $bits(entry_t);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MATCH,
		ST_SELECT,
		ST_EVAL,
		ST_UPDATE
	} state_t;

	localparam logic [1:0] CFG_ENABLE = 2'd0;
	localparam logic [1:0] CFG_WINDOW = 2'd1;
	localparam logic [1:0] CFG_LIMIT  = 2'd2;

	localparam logic [63:0] WindowReset = 64'd1000000000;
	localparam logic [31:0] LimitReset  = 32'd10000;

	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

endpackage

FILE: hdl/prl_cell.sv
module prl_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  prl_pkg::entry_t prev,
	input  logic            load,
	input  logic [31:0]     key,
	output prl_pkg::entry_t cur,
	output logic            match
);

	logic        valid_q;
	logic [31:0] addr_q;
	logic [31:0] count_q;
	logic [63:0] wstart_q;
	logic [31:0] drops_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= prev.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			addr_q   <= prev.addr;
			count_q  <= prev.count;
			wstart_q <= prev.wstart;
			drops_q  <= prev.drops;
		end
	end

	assign cur   = '{valid: valid_q, addr: addr_q, count: count_q,
		wstart: wstart_q, drops: drops_q};
	assign match = valid_q && (addr_q == key);

endmodule

FILE: hdl/per_source_rate_limiter_unit.sv
// Flow: an accepted request goes through match, select and evaluate, then
// update writes it to the output register, stalling on an unread result.
// No new request is taken before then: one shared evaluate path feeds the
// recency-ordered cell chain.
// Reset: table empty, drop total zero, config at its default values.
module per_source_rate_limiter_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] source_addr,
	input  logic [63:0] arrival_time,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        verdict,
	output logic        entry_created,
	output logic [31:0] source_drops,
	output logic [31:0] total_limited,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	localparam int N = prl_pkg::TableEntries;

	prl_pkg::state_t state_q, state_d;

	logic        enable_q;
	logic [63:0] window_q;
	logic [31:0] limit_q;
	logic [31:0] total_q;

	logic [31:0] addr_q;
	logic [63:0] time_q;
	logic        en_q;

	logic [N-1:0] match;
	logic [N-1:0] match_q;
	logic [N-1:0] shift_q;
	logic [N-1:0] suffix;
	logic         hit_q;
	logic [prl_pkg::EntryW-1:0] sel_bits;
	prl_pkg::entry_t sel_q;
	prl_pkg::entry_t new_q;
	prl_pkg::entry_t new_d;
	prl_pkg::entry_t cell_out [N];

	logic        res_verdict_q, res_created_q;
	logic [31:0] res_drops_q;
	logic        res_verdict_d, res_created_d;
	logic [31:0] res_drops_d;
	logic        out_valid_q;

	logic [63:0] elapsed;
	logic        upd_fire;

	// cell chain, most recent first
	for (genvar i = 0; i < N; i++) begin : g_cell
		prl_pkg::entry_t prev_e;
		logic            ld;
		if (i == 0) begin : g_head
			assign prev_e = new_q;
			assign ld     = upd_fire && en_q;
		end else begin : g_body
			assign prev_e = cell_out[i-1];
			assign ld     = upd_fire && en_q && (!hit_q || shift_q[i]);
		end
		prl_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.prev  (prev_e),
			.load  (ld),
			.key   (addr_q),
			.cur   (cell_out[i]),
			.match (match[i])
		);
	end

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == prl_pkg::ST_IDLE);
	assign upd_fire  = (state_q == prl_pkg::ST_UPDATE) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			window_q <= prl_pkg::WindowReset;
			limit_q  <= prl_pkg::LimitReset;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				prl_pkg::CFG_ENABLE: enable_q <= cfg_data[0];
				prl_pkg::CFG_WINDOW: window_q <= cfg_data;
				prl_pkg::CFG_LIMIT:  limit_q  <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= prl_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			prl_pkg::ST_IDLE:   if (in_valid) state_d = prl_pkg::ST_MATCH;
			prl_pkg::ST_MATCH:  state_d = prl_pkg::ST_SELECT;
			prl_pkg::ST_SELECT: state_d = prl_pkg::ST_EVAL;
			prl_pkg::ST_EVAL:   state_d = prl_pkg::ST_UPDATE;
			prl_pkg::ST_UPDATE: if (upd_fire) state_d = prl_pkg::ST_IDLE;
			default:            state_d = prl_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			addr_q <= source_addr;
			time_q <= arrival_time;
			en_q   <= enable_q;
		end
	end

	// one-hot select and suffix OR for the shift mask
	always_comb begin
		sel_bits = '0;
		for (int i = 0; i < N; i++) begin
			if (match_q[i]) sel_bits = sel_bits | cell_out[i];
		end
		suffix = match_q;
		for (int k = 0; k < prl_pkg::IdxW; k++) begin
			suffix = suffix | (suffix >> (1 << k));
		end
	end

	assign elapsed = time_q - sel_q.wstart;

	always_comb begin
		new_d         = sel_q;
		new_d.valid   = 1'b1;
		new_d.addr    = addr_q;
		res_verdict_d = 1'b0;
		res_created_d = 1'b0;
		res_drops_d   = 32'd0;
		if (en_q) begin
			if (!hit_q) begin
				new_d.count   = 32'd1;
				new_d.wstart  = time_q;
				new_d.drops   = 32'd0;
				res_created_d = 1'b1;
			end else if (elapsed > window_q) begin
				new_d.count  = 32'd1;
				new_d.wstart = time_q;
				res_drops_d  = sel_q.drops;
			end else if (sel_q.count >= limit_q) begin
				new_d.drops   = prl_pkg::sat_inc(sel_q.drops);
				res_drops_d   = prl_pkg::sat_inc(sel_q.drops);
				res_verdict_d = 1'b1;
			end else begin
				new_d.count = sel_q.count + 32'd1;
				res_drops_d = sel_q.drops;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == prl_pkg::ST_MATCH) begin
			match_q <= match;
		end
		if (state_q == prl_pkg::ST_SELECT) begin
			sel_q   <= prl_pkg::entry_t'(sel_bits);
			hit_q   <= |match_q;
			shift_q <= suffix;
		end
		if (state_q == prl_pkg::ST_EVAL) begin
			new_q         <= new_d;
			res_verdict_q <= res_verdict_d;
			res_created_q <= res_created_d;
			res_drops_q   <= res_drops_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= 32'd0;
		end else if (state_q == prl_pkg::ST_EVAL && en_q && hit_q
			&& !(elapsed > window_q) && sel_q.count >= limit_q) begin
			total_q <= prl_pkg::sat_inc(total_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (upd_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (upd_fire) begin
			verdict       <= res_verdict_q;
			entry_created <= res_created_q;
			source_drops  <= res_drops_q;
			total_limited <= total_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: hdl/prl_checker.sv
`include "per_source_rate_limiter_unit_assert.svh"

module prl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        verdict,
	input logic        entry_created,
	input logic [31:0] source_drops,
	input logic [31:0] total_limited
);

	`PRL_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(total_limited), "stall")
	`PRL_ASSERT_IMPL(a_new_passes, out_valid && entry_created, !verdict, "new source dropped")
	`PRL_ASSERT_IMPL(a_new_clean, out_valid && entry_created, source_drops == 32'd0, "new drops")
	`PRL_ASSERT_IMPL(a_cnt, out_valid && verdict, |total_limited && |source_drops, "uncounted")

endmodule

bind per_source_rate_limiter_unit prl_checker u_prl_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.verdict      (verdict),
	.entry_created(entry_created),
	.source_drops (source_drops),
	.total_limited(total_limited)
);
